FILE: design/chbd_pkg.sv
// ----------------------------------------------------------------------------
// Context Huffman bit decoder package
// Shared item, status and code types used by the front queue and the back end.
// ----------------------------------------------------------------------------
package chbd_pkg;

	// Command codes of one request.
	typedef enum logic [1:0] {
		CMD_LOAD_PLAIN = 2'd0,
		CMD_LOAD_CTX   = 2'd1,
		CMD_DECODE     = 2'd2,
		CMD_START      = 2'd3
	} cmd_t;

	// Result kinds.
	localparam logic [1:0] KIND_SYMBOL   = 2'd0;
	localparam logic [1:0] KIND_END      = 2'd1;
	localparam logic [1:0] KIND_OVERFLOW = 2'd2;

	localparam int unsigned SYM_PORT_W = 7;
	localparam int unsigned CODE_W     = 32;
	localparam int unsigned LEN_W      = 6;
	localparam int unsigned REG_W      = 8;

	// One queued request.
	typedef struct packed {
		cmd_t                    command;
		logic [SYM_PORT_W-1:0]   context_req;
		logic [SYM_PORT_W-1:0]   symbol;
		logic [CODE_W-1:0]       code_bits;
		logic [LEN_W-1:0]        code_length;
		logic                    stream_bit;
	} item_t;

	// Status from the back end to the front queue.
	typedef struct packed {
		logic take;
		logic clearing;
	} back_status_t;

endpackage

FILE: design/chbd_front.sv
// ----------------------------------------------------------------------------
// Context Huffman bit decoder front queue
// Accepts requests into a two-entry queue that the back end drains.
// ----------------------------------------------------------------------------
module chbd_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  chbd_pkg::item_t        item_in,
	input  chbd_pkg::back_status_t status,
	output logic                   q_valid,
	output chbd_pkg::item_t        q_item
);

	chbd_pkg::item_t fifo_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	logic            pop;

	// The queue takes nothing while the context table is being cleared.
	assign busy    = (count_q == 2'd2) || status.clearing;
	assign push    = start && !busy;
	assign q_valid = (count_q != 2'd0);
	assign pop     = status.take && q_valid;
	assign q_item  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

FILE: design/chbd_back.sv
// ----------------------------------------------------------------------------
// Context Huffman bit decoder back end
// Executes table loads, starts and bit decodes; scans one table entry a cycle.
// ----------------------------------------------------------------------------
module chbd_back #(
	parameter int unsigned MAX_CODE_LEN = 32,
	parameter int unsigned NUM_SYMBOLS  = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  chbd_pkg::item_t               q_item,
	output chbd_pkg::back_status_t        status,
	input  logic                          cfg_we,
	input  logic                          cfg_sel,
	input  logic [chbd_pkg::REG_W-1:0]    cfg_wdata,
	output logic                          res_valid,
	output logic [chbd_pkg::SYM_PORT_W-1:0] res_symbol,
	output logic [1:0]                    res_kind
);

	localparam int unsigned SYM_W     = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
	localparam int unsigned CTX_DEPTH = NUM_SYMBOLS * NUM_SYMBOLS;
	localparam int unsigned CTX_AW    = $clog2(CTX_DEPTH);
	localparam int unsigned LIMIT     = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
	localparam int unsigned ENT_W     = chbd_pkg::LEN_W + chbd_pkg::CODE_W;
	localparam logic [SYM_W-1:0]  LAST_SYM = SYM_W'(NUM_SYMBOLS - 1);
	localparam logic [CTX_AW-1:0] LAST_CTX = CTX_AW'(CTX_DEPTH - 1);
	localparam logic [chbd_pkg::LEN_W-1:0] LIMIT_L = chbd_pkg::LEN_W'(LIMIT);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t                state_q;
	logic [CTX_AW-1:0]     clr_q;
	logic [chbd_pkg::REG_W-1:0] end_sym_q;
	logic [chbd_pkg::REG_W-1:0] esc_sym_q;
	logic [31:0]           prefix_q;
	logic [chbd_pkg::LEN_W-1:0] cnt_q;
	logic [31:0]           mask_q;
	logic [SYM_W-1:0]      prev_q;
	logic                  first_q;
	logic                  esc_act_q;
	logic                  done_q;
	logic                  use_plain_q;
	logic [SYM_W-1:0]      addr_q;
	logic                  issue_q;
	logic                  vld_s1;
	logic [SYM_W-1:0]      idx_s1;
	logic                  pv_s1;
	logic [ENT_W-1:0]      plain_rd_s1;
	logic [ENT_W-1:0]      ctx_rd_s1;
	logic                  plain_valid_q [NUM_SYMBOLS];
	logic                  present_q [NUM_SYMBOLS];
	logic                  res_valid_q;
	logic [chbd_pkg::SYM_PORT_W-1:0] res_symbol_q;
	logic [1:0]            res_kind_q;

	logic [ENT_W-1:0]      plain_mem [NUM_SYMBOLS];
	logic [ENT_W-1:0]      ctx_mem [CTX_DEPTH];

	logic                  take;
	logic                  sym_ok;
	logic                  ctx_ok;
	logic [SYM_W-1:0]      ld_sym;
	logic [SYM_W-1:0]      ld_ctx;
	logic                  pm_we;
	logic                  cm_we;
	logic [CTX_AW-1:0]     cm_wa;
	logic [ENT_W-1:0]      cm_wd;
	logic [CTX_AW-1:0]     cm_ra;
	logic [ENT_W-1:0]      ent;
	logic [chbd_pkg::LEN_W-1:0] ent_len;
	logic [31:0]           ent_bits;
	logic                  hit_s1;
	logic                  is_esc;
	logic                  is_end;
	logic [chbd_pkg::LEN_W-1:0] cnt_next;
	logic [32:0]           mask_full;

	assign take            = (state_q == ST_IDLE) && q_valid;
	assign status.take     = take;
	assign status.clearing = (state_q == ST_CLEAR);

	assign sym_ok = 9'(q_item.symbol) < 9'(NUM_SYMBOLS);
	assign ctx_ok = 9'(q_item.context_req) < 9'(NUM_SYMBOLS);
	assign ld_sym = SYM_W'(q_item.symbol);
	assign ld_ctx = SYM_W'(q_item.context_req);

	assign pm_we = take && (q_item.command == chbd_pkg::CMD_LOAD_PLAIN) && sym_ok;

	always_comb begin
		cm_we = 1'b0;
		cm_wa = clr_q;
		cm_wd = '0;
		if (state_q == ST_CLEAR) begin
			cm_we = 1'b1;
		end else if (take && (q_item.command == chbd_pkg::CMD_LOAD_CTX) && sym_ok && ctx_ok) begin
			cm_we = 1'b1;
			cm_wa = CTX_AW'(CTX_AW'(ld_ctx) * CTX_AW'(NUM_SYMBOLS) + CTX_AW'(ld_sym));
			cm_wd = {q_item.code_length, q_item.code_bits};
		end
	end

	assign cm_ra = CTX_AW'(CTX_AW'(prev_q) * CTX_AW'(NUM_SYMBOLS) + CTX_AW'(addr_q));

	always_ff @(posedge clk) begin
		if (pm_we) begin
			plain_mem[ld_sym] <= {q_item.code_length, q_item.code_bits};
		end
		plain_rd_s1 <= plain_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (cm_we) begin
			ctx_mem[cm_wa] <= cm_wd;
		end
		ctx_rd_s1 <= ctx_mem[cm_ra];
	end

	// Compare of one fetched entry against the gathered prefix.
	assign ent      = use_plain_q ? plain_rd_s1 : ctx_rd_s1;
	assign ent_len  = ent[ENT_W-1:chbd_pkg::CODE_W];
	assign ent_bits = ent[chbd_pkg::CODE_W-1:0];
	assign hit_s1   = vld_s1 && (ent_len == cnt_q) && (ent_len <= LIMIT_L) &&
	                  ((ent_bits & mask_q) == prefix_q) && (!use_plain_q || pv_s1);
	assign is_esc   = !use_plain_q && (9'(idx_s1) == 9'(esc_sym_q));
	assign is_end   = 9'(idx_s1) == 9'(end_sym_q);

	assign cnt_next  = cnt_q + chbd_pkg::LEN_W'(1);
	assign mask_full = (33'd1 << cnt_next) - 33'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			end_sym_q    <= chbd_pkg::REG_W'(128);
			esc_sym_q    <= chbd_pkg::REG_W'(128);
			prefix_q     <= '0;
			cnt_q        <= '0;
			mask_q       <= '0;
			prev_q       <= '0;
			first_q      <= 1'b1;
			esc_act_q    <= 1'b0;
			done_q       <= 1'b0;
			use_plain_q  <= 1'b1;
			addr_q       <= '0;
			issue_q      <= 1'b0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			pv_s1        <= 1'b0;
			res_valid_q  <= 1'b0;
			res_symbol_q <= '0;
			res_kind_q   <= chbd_pkg::KIND_SYMBOL;
			for (int i = 0; i < NUM_SYMBOLS; i++) begin
				plain_valid_q[i] <= 1'b0;
				present_q[i]     <= 1'b0;
			end
		end else begin
			res_valid_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_sel) begin
					esc_sym_q <= cfg_wdata;
				end else begin
					end_sym_q <= cfg_wdata;
				end
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CTX_AW'(1);
					if (clr_q == LAST_CTX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (take) begin
						case (q_item.command)
							chbd_pkg::CMD_LOAD_PLAIN: begin
								if (sym_ok) begin
									plain_valid_q[ld_sym] <= 1'b1;
								end
							end
							chbd_pkg::CMD_LOAD_CTX: begin
								if (sym_ok && ctx_ok && (q_item.code_length != '0)) begin
									present_q[ld_ctx] <= 1'b1;
								end
							end
							chbd_pkg::CMD_START: begin
								prefix_q  <= '0;
								cnt_q     <= '0;
								first_q   <= 1'b1;
								esc_act_q <= 1'b0;
								done_q    <= 1'b0;
							end
							chbd_pkg::CMD_DECODE: begin
								if (!done_q) begin
									prefix_q    <= {prefix_q[30:0], q_item.stream_bit};
									cnt_q       <= cnt_next;
									mask_q      <= mask_full[31:0];
									use_plain_q <= first_q || esc_act_q || !present_q[prev_q];
									addr_q      <= '0;
									issue_q     <= 1'b1;
									vld_s1      <= 1'b0;
									state_q     <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					// Fetch stage: one table address per cycle.
					vld_s1 <= issue_q;
					idx_s1 <= addr_q;
					pv_s1  <= plain_valid_q[addr_q];
					if (issue_q) begin
						if (addr_q == LAST_SYM) begin
							issue_q <= 1'b0;
						end else begin
							addr_q <= addr_q + SYM_W'(1);
						end
					end
					// Compare stage: the first hit ends the scan.
					if (hit_s1) begin
						prefix_q <= '0;
						cnt_q    <= '0;
						issue_q  <= 1'b0;
						vld_s1   <= 1'b0;
						state_q  <= ST_IDLE;
						if (is_esc) begin
							esc_act_q <= 1'b1;
						end else if (is_end) begin
							done_q       <= 1'b1;
							res_valid_q  <= 1'b1;
							res_symbol_q <= '0;
							res_kind_q   <= chbd_pkg::KIND_END;
						end else begin
							prev_q       <= idx_s1;
							first_q      <= 1'b0;
							esc_act_q    <= 1'b0;
							res_valid_q  <= 1'b1;
							res_symbol_q <= chbd_pkg::SYM_PORT_W'(idx_s1);
							res_kind_q   <= chbd_pkg::KIND_SYMBOL;
						end
					end else if (vld_s1 && (idx_s1 == LAST_SYM)) begin
						vld_s1  <= 1'b0;
						state_q <= ST_IDLE;
						if (cnt_q >= LIMIT_L) begin
							prefix_q     <= '0;
							cnt_q        <= '0;
							res_valid_q  <= 1'b1;
							res_symbol_q <= '0;
							res_kind_q   <= chbd_pkg::KIND_OVERFLOW;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid  = res_valid_q;
	assign res_symbol = res_symbol_q;
	assign res_kind   = res_kind_q;

`ifndef SYNTHESIS
	a_no_take_while_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !take)
		else $error("request taken during table clear");
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |=> !res_valid_q)
		else $error("two results in consecutive cycles");
	a_nonsymbol_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_kind_q != chbd_pkg::KIND_SYMBOL)) |-> (res_symbol_q == '0))
		else $error("end or overflow result carries a symbol");
	a_prefix_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= LIMIT_L))
		else $error("prefix grew past the code length limit");
`endif

endmodule

FILE: design/context_huffman_bit_decoder_top.sv
// ----------------------------------------------------------------------------
// Context Huffman bit decoder top level
// Bit-serial Huffman decoder with a plain code table and per-context tables.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Load and start
// requests need no table scan in the back end; a decode-bit request scans
// the selected code table one entry per cycle through its single read port.
// A two-entry queue lets the next requests be taken while a scan is running.
// Results (kind 0 symbol, 1 end of data, 2 prefix overflow) appear on
// decoded_symbol and kind for exactly one cycle while result_valid is high;
// the receiver cannot hold them off. After reset the context table memory is
// cleared one entry per cycle, and busy stays high until it is cleared.
// Configuration writes are always ready, but they should only be made while
// the decoder is idle.
// ----------------------------------------------------------------------------
module context_huffman_bit_decoder_top #(
	parameter int unsigned MAX_CODE_LEN = 32,
	parameter int unsigned NUM_SYMBOLS  = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [6:0]  context_req,
	input  logic [6:0]  symbol,
	input  logic [31:0] code_bits,
	input  logic [5:0]  code_length,
	input  logic        stream_bit,
	output logic        result_valid,
	output logic [6:0]  decoded_symbol,
	output logic [1:0]  kind,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	chbd_pkg::item_t        item_in;
	chbd_pkg::item_t        q_item;
	chbd_pkg::back_status_t status;
	logic                   q_valid;

	// Pack the request fields into one queue entry.
	assign item_in.command     = chbd_pkg::cmd_t'(command);
	assign item_in.context_req = context_req;
	assign item_in.symbol      = symbol;
	assign item_in.code_bits   = code_bits;
	assign item_in.code_length = code_length;
	assign item_in.stream_bit  = stream_bit;

	// Register writes complete at once.
	assign cfg_ready = 1'b1;

	chbd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item_in (item_in),
		.status  (status),
		.q_valid (q_valid),
		.q_item  (q_item)
	);

	chbd_back #(
		.MAX_CODE_LEN (MAX_CODE_LEN),
		.NUM_SYMBOLS  (NUM_SYMBOLS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.status     (status),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_sel    (cfg_index),
		.cfg_wdata  (cfg_data),
		.res_valid  (result_valid),
		.res_symbol (decoded_symbol),
		.res_kind   (kind)
	);

endmodule

FILE: tb/tb_context_huffman_bit_decoder_top.sv
// ----------------------------------------------------------------------------
// Context Huffman bit decoder testbench
// Drives load, start and decode-bit requests with random idle gaps, predicts
// every result from an internal copy of the code tables and decoder state,
// and checks each result strobe field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_context_huffman_bit_decoder_top;

	localparam int unsigned SYMS    = 128;
	localparam int unsigned LEN_MAX = 32;
	localparam bit REG_END    = 1'b0;
	localparam bit REG_ESCAPE = 1'b1;
	localparam logic [7:0] SYM_NONE = 8'd128;

	// One entry of the stimulus queue: either a request or a register write.
	typedef struct {
		bit              is_cfg;
		bit              reg_idx;
		logic [7:0]      reg_val;
		chbd_pkg::item_t req;
	} stim_t;

	// One predicted result.
	typedef struct {
		logic [6:0] sym;
		logic [1:0] kind;
	} decode_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  command = chbd_pkg::CMD_START;
	logic [6:0]  context_req = '0;
	logic [6:0]  symbol = '0;
	logic [31:0] code_bits = '0;
	logic [5:0]  code_length = '0;
	logic        stream_bit = 1'b0;
	logic        result_valid;
	logic [6:0]  decoded_symbol;
	logic [1:0]  kind;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [7:0]  cfg_data = '0;

	context_huffman_bit_decoder_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .context_req(context_req), .symbol(symbol),
		.code_bits(code_bits), .code_length(code_length), .stream_bit(stream_bit),
		.result_valid(result_valid), .decoded_symbol(decoded_symbol), .kind(kind),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Shadow copy of the decoder: code tables, stream state and registers.
	logic [31:0] plain_code [SYMS];
	logic [5:0]  plain_width [SYMS];
	logic [31:0] ctx_code [SYMS*SYMS];
	logic [5:0]  ctx_width [SYMS*SYMS];
	bit          ctx_loaded [SYMS];
	logic [31:0] shift_bits;
	int unsigned shift_count;
	int unsigned last_sym;
	bit          at_first;
	bit          in_escape;
	bit          halted;
	logic [7:0]  end_sym;
	logic [7:0]  esc_sym;

	stim_t       pending [$];
	decode_out_t decode_expect [$];
	stim_t       cur;
	int          gap_left = 0;
	bit          calm = 1'b0;
	int          errors = 0;
	int          reqs_done = 0;
	int          n_sym = 0, n_end = 0, n_ovf = 0, n_esc = 0;

	initial begin
		for (int i = 0; i < SYMS; i++) begin
			plain_code[i] = '0;
			plain_width[i] = '0;
			ctx_loaded[i] = 1'b0;
		end
		for (int i = 0; i < SYMS*SYMS; i++) begin
			ctx_code[i] = '0;
			ctx_width[i] = '0;
		end
		shift_bits = '0;
		shift_count = 0;
		last_sym = 0;
		at_first = 1'b1;
		in_escape = 1'b0;
		halted = 1'b0;
		end_sym = SYM_NONE;
		esc_sym = SYM_NONE;
	end

	// A code matches when it is valid, within the length limit, exactly as long
	// as the gathered prefix, and its low bits equal the prefix.
	function automatic bit code_hit(logic [31:0] bits, logic [5:0] len);
		logic [63:0] mask;
		if (len == 0 || len > LEN_MAX || len != shift_count)
			return 1'b0;
		mask = (64'd1 << len) - 64'd1;
		return ({32'd0, bits} & mask) == {32'd0, shift_bits};
	endfunction

	// Applies one accepted request to the shadow state and queues any result.
	task automatic decode_predict(chbd_pkg::item_t r);
		bit          plain;
		bit          hit;
		int unsigned e;
		decode_out_t o;
		case (r.command)
			chbd_pkg::CMD_LOAD_PLAIN: begin
				plain_code[r.symbol] = r.code_bits;
				plain_width[r.symbol] = r.code_length;
			end
			chbd_pkg::CMD_LOAD_CTX: begin
				e = r.context_req * SYMS + r.symbol;
				ctx_code[e] = r.code_bits;
				ctx_width[e] = r.code_length;
				if (r.code_length != 0)
					ctx_loaded[r.context_req] = 1'b1;
			end
			chbd_pkg::CMD_START: begin
				shift_bits = '0;
				shift_count = 0;
				at_first = 1'b1;
				in_escape = 1'b0;
				halted = 1'b0;
			end
			default: begin
				if (halted)
					return;
				shift_bits = {shift_bits[30:0], r.stream_bit};
				shift_count++;
				plain = at_first || in_escape || !ctx_loaded[last_sym];
				for (int j = 0; j < SYMS; j++) begin
					e = last_sym * SYMS + j;
					hit = plain ? code_hit(plain_code[j], plain_width[j])
						: code_hit(ctx_code[e], ctx_width[e]);
					if (hit) begin
						shift_bits = '0;
						shift_count = 0;
						if (!plain && j == esc_sym) begin
							in_escape = 1'b1;
							n_esc++;
							return;
						end
						if (j == end_sym) begin
							halted = 1'b1;
							o.sym = '0;
							o.kind = chbd_pkg::KIND_END;
						end else begin
							last_sym = j;
							at_first = 1'b0;
							in_escape = 1'b0;
							o.sym = j[6:0];
							o.kind = chbd_pkg::KIND_SYMBOL;
						end
						decode_expect.push_back(o);
						return;
					end
				end
				if (shift_count >= LEN_MAX) begin
					shift_bits = '0;
					shift_count = 0;
					o.sym = '0;
					o.kind = chbd_pkg::KIND_OVERFLOW;
					decode_expect.push_back(o);
				end
			end
		endcase
	endtask

	// Driver: holds a request or a register write until it is taken, then
	// moves on to the next queued entry, sometimes after a short idle burst.
	// Each control signal gets exactly one nonblocking update per edge.
	always @(posedge clk) begin : driver
		bit nxt_start;
		bit nxt_cfg;
		nxt_start = start;
		nxt_cfg = cfg_valid;
		if (arst_n) begin
			if (start && !busy) begin
				decode_predict(cur.req);
				reqs_done++;
				nxt_start = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				if (cur.reg_idx == REG_END)
					end_sym = cur.reg_val;
				else
					esc_sym = cur.reg_val;
				nxt_cfg = 1'b0;
			end
			if (!nxt_start && !nxt_cfg) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending.size() > 0) begin
					if (!calm && $urandom_range(0, 7) == 0) begin
						gap_left = $urandom_range(1, 6) - 1;
					end else begin
						cur = pending.pop_front();
						if (cur.is_cfg)
							nxt_cfg = 1'b1;
						else
							nxt_start = 1'b1;
					end
				end
			end
		end
		start <= nxt_start;
		cfg_valid <= nxt_cfg;
		command <= cur.req.command;
		context_req <= cur.req.context_req;
		symbol <= cur.req.symbol;
		code_bits <= cur.req.code_bits;
		code_length <= cur.req.code_length;
		stream_bit <= cur.req.stream_bit;
		cfg_index <= cur.reg_idx;
		cfg_data <= cur.reg_val;
	end

	// Monitor: every strobed result must match the oldest prediction.
	always @(posedge clk) begin : monitor
		decode_out_t want;
		if (arst_n && result_valid) begin
			if (decode_expect.size() == 0) begin
				$display("%0t: unexpected result symbol %0d kind %0d", $time,
					decoded_symbol, kind);
				errors++;
			end else begin
				want = decode_expect.pop_front();
				if (kind !== want.kind) begin
					$display("%0t: kind mismatch, expected %0d, actual %0d", $time,
						want.kind, kind);
					errors++;
				end
				if (decoded_symbol !== want.sym) begin
					$display("%0t: symbol mismatch, expected %0d, actual %0d", $time,
						want.sym, decoded_symbol);
					errors++;
				end
				case (want.kind)
					chbd_pkg::KIND_SYMBOL: n_sym++;
					chbd_pkg::KIND_END:    n_end++;
					default:               n_ovf++;
				endcase
			end
		end
	end

	task automatic add_req(chbd_pkg::cmd_t c, int ctx, int sym, logic [31:0] bits, int len,
		bit b);
		stim_t s;
		s.is_cfg = 1'b0;
		s.reg_idx = REG_END;
		s.reg_val = '0;
		s.req.command = c;
		s.req.context_req = ctx[6:0];
		s.req.symbol = sym[6:0];
		s.req.code_bits = bits;
		s.req.code_length = len[5:0];
		s.req.stream_bit = b;
		pending.push_back(s);
	endtask

	task automatic add_cfg(bit idx, logic [7:0] val);
		stim_t s;
		s = cur;
		s.is_cfg = 1'b1;
		s.reg_idx = idx;
		s.reg_val = val;
		pending.push_back(s);
	endtask

	// Waits until every queued entry is taken and every result has arrived,
	// then lets enough full table scans pass for the running request and both
	// queued ones to finish.
	task automatic drain();
		while (pending.size() != 0 || start || cfg_valid || decode_expect.size() != 0)
			@(posedge clk);
		repeat (4 * (SYMS + 2)) @(posedge clk);
	endtask

	initial begin : stimulus
		int set [8];
		int prev_set [8];
		int rot;
		int pick;
		bit dup;
		logic [31:0] long_code;
		cur.is_cfg = 1'b0;
		cur.reg_idx = REG_END;
		cur.reg_val = '0;
		cur.req = '0;
		cur.req.command = chbd_pkg::CMD_START;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening: empty tables, lowest symbol winning a shared code,
		// a context lookup, a context with no table, and invalidation.
		add_req(chbd_pkg::CMD_START, 0, 0, '0, 0, 0);
		add_req(chbd_pkg::CMD_DECODE, 0, 0, '0, 0, 1);
		add_req(chbd_pkg::CMD_START, 0, 0, '0, 0, 0);
		add_req(chbd_pkg::CMD_LOAD_PLAIN, 0, 127, 32'hFFFF_FFFF, 1, 0);
		add_req(chbd_pkg::CMD_LOAD_PLAIN, 0, 5, 32'hAAAA_AAAB, 1, 0);
		add_req(chbd_pkg::CMD_LOAD_PLAIN, 0, 0, 32'h5555_5554, 1, 0);
		add_req(chbd_pkg::CMD_LOAD_CTX, 0, 127, 32'h0000_0001, 1, 0);
		add_req(chbd_pkg::CMD_LOAD_CTX, 127, 0, 32'h0000_0000, 0, 0);
		add_req(chbd_pkg::CMD_START, 0, 0, '0, 0, 0);
		add_req(chbd_pkg::CMD_DECODE, 0, 0, '0, 0, 1);
		add_req(chbd_pkg::CMD_DECODE, 0, 0, '0, 0, 0);
		add_req(chbd_pkg::CMD_DECODE, 0, 0, '0, 0, 1);
		add_req(chbd_pkg::CMD_DECODE, 0, 0, '0, 0, 1);
		add_req(chbd_pkg::CMD_DECODE, 0, 0, '0, 0, 0);
		add_req(chbd_pkg::CMD_LOAD_PLAIN, 0, 127, 32'h0, 0, 0);
		add_req(chbd_pkg::CMD_LOAD_PLAIN, 0, 5, 32'h0, 0, 0);
		add_req(chbd_pkg::CMD_LOAD_PLAIN, 0, 0, 32'h0, 0, 0);
		drain();

		for (int k = 0; k < 8; k++)
			prev_set[k] = 0;
		for (int ph = 0; ph < 6; ph++) begin
			// Register settings move through none, the extremes, separate end and
			// escape symbols, and escape equal to end.
			for (int k = 0; k < 8; k++) begin
				do begin
					pick = (ph == 0 && k == 0) ? 0 : (ph == 0 && k == 1) ? 127
						: $urandom_range(0, 127);
					dup = 1'b0;
					for (int m = 0; m < k; m++)
						if (set[m] == pick)
							dup = 1'b1;
				end while (dup);
				set[k] = pick;
			end
			case (ph)
				0: begin add_cfg(REG_END, SYM_NONE); add_cfg(REG_ESCAPE, SYM_NONE); end
				1: begin add_cfg(REG_END, set[7][7:0]); add_cfg(REG_ESCAPE, set[6][7:0]); end
				2: begin add_cfg(REG_END, set[5][7:0]); add_cfg(REG_ESCAPE, set[5][7:0]); end
				3: begin add_cfg(REG_END, 8'd0); add_cfg(REG_ESCAPE, 8'd127); end
				4: begin add_cfg(REG_END, SYM_NONE); add_cfg(REG_ESCAPE, set[2][7:0]); end
				default: begin
					add_cfg(REG_END, set[4][7:0]);
					add_cfg(REG_ESCAPE, set[3][7:0]);
					calm = 1'b1;
				end
			endcase

			// Drop the previous plain codes, then load three-bit code sets (random bits
			// above the code), complete but in phase 3, so random streams keep decoding.
			for (int k = 0; k < 8; k++)
				add_req(chbd_pkg::CMD_LOAD_PLAIN, 0, prev_set[k], $urandom(), 0, 0);
			rot = $urandom_range(0, 7);
			for (int k = 0; k < 8; k++)
				if (ph != 3 || k < 6)
					add_req(chbd_pkg::CMD_LOAD_PLAIN, 0, set[k],
						($urandom() & 32'hFFFF_FFF8) | (k ^ rot), 3, 0);
			for (int c = 0; c < 4; c++) begin
				rot = $urandom_range(0, 7);
				for (int k = 0; k < 8; k++)
					if (ph != 3 || k != c)
						add_req(chbd_pkg::CMD_LOAD_CTX, set[c], set[k],
							($urandom() & 32'hFFFF_FFF8) | (k ^ rot), 3, 0);
			end

			// The incomplete-table phase also carries a full-length code that is
			// fed once bit by bit; elsewhere stray prefixes run into overflow.
			add_req(chbd_pkg::CMD_START, 0, 0, '0, 0, 0);
			if (ph == 3) begin
				long_code = $urandom() | 32'hE000_0000;
				add_req(chbd_pkg::CMD_LOAD_PLAIN, 0, set[7], long_code, LEN_MAX, 0);
				add_req(chbd_pkg::CMD_START, 0, 0, '0, 0, 0);
				for (int b = 31; b >= 0; b--)
					add_req(chbd_pkg::CMD_DECODE, 0, 0, '0, 0, long_code[b]);
			end
			for (int n = 0; n < 125; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 3)
					add_req(chbd_pkg::CMD_START, 0, 0, '0, 0, 0);
				else if (pick < 5)
					add_req(chbd_pkg::CMD_LOAD_CTX, $urandom_range(0, 127),
						$urandom_range(0, 127), $urandom(), $urandom_range(0, 32),
						$urandom_range(0, 1));
				else if (pick < 6)
					add_req(chbd_pkg::CMD_LOAD_PLAIN, $urandom_range(0, 127),
						set[$urandom_range(0, 7)], $urandom(), $urandom_range(0, 32),
						$urandom_range(0, 1));
				else
					add_req(chbd_pkg::CMD_DECODE, $urandom_range(0, 127),
						$urandom_range(0, 127), $urandom(), $urandom_range(0, 63),
						$urandom_range(0, 1));
			end
			prev_set = set;
			// The sender pauses here until every predicted result has come back.
			drain();
		end

		$display("Covered %0d requests: %0d symbols, %0d end markers, %0d overflows,",
			reqs_done, n_sym, n_end, n_ovf);
		$display("and %0d escapes over six table and register settings.", n_esc);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Guard against a hung handshake; the slowest correct run is far shorter.
	initial begin : watchdog
		#20000000;
		$display("Verification failed");
		$finish;
	end

endmodule

FILE: sim.f
design/chbd_pkg.sv
design/chbd_front.sv
design/chbd_back.sv
design/context_huffman_bit_decoder_top.sv
tb/tb_context_huffman_bit_decoder_top.sv
